FILE: hw/rtl/jsu_pkg.sv
package jsu_pkg;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TEXT,
    PH_ESC,
    PH_HEX1,
    PH_WANTBS,
    PH_WANTU,
    PH_HEX2
  } phase_t;

  // Result status codes
  typedef enum logic [3:0] {
    ST_BUSY           = 4'd0,
    ST_DONE           = 4'd1,
    ST_EXPECTED       = 4'd2,
    ST_CTRL           = 4'd3,
    ST_UNTERM_ESC     = 4'd4,
    ST_BAD_UNICODE    = 4'd5,
    ST_MISSING_LOW    = 4'd6,
    ST_BAD_LOW        = 4'd7,
    ST_UNEXPECTED_LOW = 4'd8,
    ST_BAD_ESCAPE     = 4'd9,
    ST_UNTERM         = 4'd10
  } status_t;

  // Input kind codes
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Characters of interest
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Surrogate ranges
  localparam logic [15:0] HI_SUR_MIN = 16'hD800;
  localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  // Up to four result bytes per item
  localparam int unsigned MAX_RES = 4;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [1:0]              last_idx;
  } utf8_t;

  // Everything one item produces, handed to the output stage
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [1:0]              last_idx;
    logic                    byte_valid;
    status_t                 status;
  } bundle_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.val = 4'(c - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r.bytes    = '0;
    r.last_idx = 2'd0;
    if (cp <= 21'h7F) begin
      r.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.last_idx = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.last_idx = 2'd2;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.last_idx = 2'd3;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/json_string_unescape_utf8.sv
// JSON string unescaper. Feed a quoted JSON string one byte per item (kind 0), or an
// end-of-input marker (kind 1); the block returns the decoded string as UTF-8 bytes with
// status busy, and ends with a single result carrying done or an error code, after which
// it waits for a new opening quote. Every item gives at least one result; last marks the
// final one. The block takes one item per cycle as long as each item yields one result
// and out_stall is low; a \u escape completing a code point yields one to four bytes,
// and a result of more than one byte holds the output register while its bytes go out
// one at a time, stalling the input behind it. Items pass through an input register and
// a result register; an item waits in the input register while the result register is
// busy. Bytes already delivered before an error are not withdrawn.
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic [3:0] status,
  output logic       last
);

  logic             in_vld;
  logic             in_kind;
  logic [7:0]       in_data;
  logic             free;
  logic             advance;
  jsu_pkg::bundle_t bundle;

  assign advance  = in_vld & free;
  assign in_stall = in_vld & ~free;

  // Capture an item; release it once it is decoded
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_kind <= kind;
      in_data <= in_byte;
    end
  end

  jsu_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .kind    (in_kind),
    .in_byte (in_data),
    .bundle  (bundle)
  );

  jsu_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .bundle     (bundle),
    .free       (free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .status     (status),
    .last       (last)
  );

endmodule

FILE: hw/rtl/jsu_decode.sv
module jsu_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             kind,
  input  logic [7:0]       in_byte,
  output jsu_pkg::bundle_t bundle
);

  jsu_pkg::phase_t phase, phase_next;
  logic [15:0]     high_unit, high_next;
  logic [15:0]     low_unit, low_next;
  logic [1:0]      digit_count, count_next;
  logic            low_bad_pending, bad_next;

  jsu_pkg::hex_t    hex;
  jsu_pkg::utf8_t   enc;
  jsu_pkg::status_t fin_status;
  logic             fin;
  logic             emit;
  logic [20:0]      cp;
  logic [15:0]      hi_shift;
  logic [15:0]      lo_new;
  logic             bad_new;

  assign hex      = jsu_pkg::hex_decode(in_byte);
  assign hi_shift = {high_unit[11:0], hex.val};
  assign lo_new   = hex.ok ? {low_unit[11:0], hex.val} : low_unit;
  assign bad_new  = low_bad_pending | ~hex.ok;

  // Hold decoder state; advance it once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= jsu_pkg::PH_IDLE;
      digit_count     <= 2'd0;
      low_bad_pending <= 1'b0;
    end else if (advance) begin
      phase           <= phase_next;
      digit_count     <= count_next;
      low_bad_pending <= bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      high_unit <= high_next;
      low_unit  <= low_next;
    end
  end

  // Next state and result for the current item
  always_comb begin
    phase_next        = phase;
    high_next         = high_unit;
    low_next          = low_unit;
    count_next        = digit_count;
    bad_next          = low_bad_pending;
    fin               = 1'b0;
    fin_status        = jsu_pkg::ST_BUSY;
    emit              = 1'b0;
    cp                = 21'd0;
    enc               = jsu_pkg::utf8_encode(cp);
    bundle.bytes      = '0;
    bundle.last_idx   = 2'd0;
    bundle.byte_valid = 1'b0;
    bundle.status     = jsu_pkg::ST_BUSY;

    if (kind == jsu_pkg::KIND_END) begin
      fin = 1'b1;
      unique case (phase) inside
        jsu_pkg::PH_TEXT:   fin_status = jsu_pkg::ST_UNTERM;
        jsu_pkg::PH_ESC:    fin_status = jsu_pkg::ST_UNTERM_ESC;
        jsu_pkg::PH_HEX1:   fin_status = jsu_pkg::ST_BAD_UNICODE;
        jsu_pkg::PH_WANTBS, jsu_pkg::PH_WANTU, jsu_pkg::PH_HEX2:
          fin_status = jsu_pkg::ST_MISSING_LOW;
        default:            fin_status = jsu_pkg::ST_EXPECTED;
      endcase
    end else begin
      unique case (phase)
        jsu_pkg::PH_IDLE: begin
          if (in_byte == jsu_pkg::CH_QUOTE) begin
            phase_next = jsu_pkg::PH_TEXT;
          end else begin
            fin        = 1'b1;
            fin_status = jsu_pkg::ST_EXPECTED;
          end
        end
        jsu_pkg::PH_TEXT: begin
          if (in_byte == jsu_pkg::CH_QUOTE) begin
            fin        = 1'b1;
            fin_status = jsu_pkg::ST_DONE;
          end else if (in_byte < jsu_pkg::CH_SPACE) begin
            fin        = 1'b1;
            fin_status = jsu_pkg::ST_CTRL;
          end else if (in_byte == jsu_pkg::CH_BSLASH) begin
            phase_next = jsu_pkg::PH_ESC;
          end else begin
            bundle.bytes[0]   = in_byte;
            bundle.byte_valid = 1'b1;
          end
        end
        jsu_pkg::PH_ESC: begin
          phase_next        = jsu_pkg::PH_TEXT;
          bundle.byte_valid = 1'b1;
          unique case (in_byte)
            jsu_pkg::CH_QUOTE:  bundle.bytes[0] = jsu_pkg::CH_QUOTE;
            jsu_pkg::CH_BSLASH: bundle.bytes[0] = jsu_pkg::CH_BSLASH;
            jsu_pkg::CH_SLASH:  bundle.bytes[0] = jsu_pkg::CH_SLASH;
            jsu_pkg::CH_LOW_B:  bundle.bytes[0] = 8'h08;
            jsu_pkg::CH_LOW_F:  bundle.bytes[0] = 8'h0C;
            jsu_pkg::CH_LOW_N:  bundle.bytes[0] = 8'h0A;
            jsu_pkg::CH_LOW_R:  bundle.bytes[0] = 8'h0D;
            jsu_pkg::CH_LOW_T:  bundle.bytes[0] = 8'h09;
            jsu_pkg::CH_LOW_U: begin
              bundle.byte_valid = 1'b0;
              phase_next        = jsu_pkg::PH_HEX1;
              high_next         = 16'd0;
              count_next        = 2'd0;
            end
            default: begin
              bundle.byte_valid = 1'b0;
              fin               = 1'b1;
              fin_status        = jsu_pkg::ST_BAD_ESCAPE;
            end
          endcase
        end
        jsu_pkg::PH_HEX1: begin
          if (!hex.ok) begin
            fin        = 1'b1;
            fin_status = jsu_pkg::ST_BAD_UNICODE;
          end else begin
            high_next = hi_shift;
            if (digit_count == 2'd3) begin
              count_next = 2'd0;
              if (hi_shift >= jsu_pkg::HI_SUR_MIN && hi_shift <= jsu_pkg::HI_SUR_MAX) begin
                phase_next = jsu_pkg::PH_WANTBS;
              end else if (hi_shift >= jsu_pkg::LO_SUR_MIN &&
                           hi_shift <= jsu_pkg::LO_SUR_MAX) begin
                fin        = 1'b1;
                fin_status = jsu_pkg::ST_UNEXPECTED_LOW;
              end else begin
                phase_next = jsu_pkg::PH_TEXT;
                emit       = 1'b1;
                cp         = {5'd0, hi_shift};
              end
            end else begin
              count_next = digit_count + 2'd1;
            end
          end
        end
        jsu_pkg::PH_WANTBS: begin
          if (in_byte == jsu_pkg::CH_BSLASH) begin
            phase_next = jsu_pkg::PH_WANTU;
          end else begin
            fin        = 1'b1;
            fin_status = jsu_pkg::ST_MISSING_LOW;
          end
        end
        jsu_pkg::PH_WANTU: begin
          if (in_byte == jsu_pkg::CH_LOW_U) begin
            phase_next = jsu_pkg::PH_HEX2;
            low_next   = 16'd0;
            count_next = 2'd0;
            bad_next   = 1'b0;
          end else begin
            fin        = 1'b1;
            fin_status = jsu_pkg::ST_MISSING_LOW;
          end
        end
        jsu_pkg::PH_HEX2: begin
          low_next = lo_new;
          bad_next = bad_new;
          if (digit_count == 2'd3) begin
            if (bad_new || lo_new < jsu_pkg::LO_SUR_MIN || lo_new > jsu_pkg::LO_SUR_MAX) begin
              fin        = 1'b1;
              fin_status = jsu_pkg::ST_BAD_LOW;
            end else begin
              count_next = 2'd0;
              phase_next = jsu_pkg::PH_TEXT;
              emit       = 1'b1;
              cp         = jsu_pkg::SUPP_BASE + {1'b0, high_unit[9:0], lo_new[9:0]};
            end
          end else begin
            count_next = digit_count + 2'd1;
          end
        end
        default: begin
          fin        = 1'b1;
          fin_status = jsu_pkg::ST_EXPECTED;
        end
      endcase
    end

    // Encode a decoded code point as UTF-8
    if (emit) begin
      enc               = jsu_pkg::utf8_encode(cp);
      bundle.bytes      = enc.bytes;
      bundle.last_idx   = enc.last_idx;
      bundle.byte_valid = 1'b1;
    end

    // Drop back to idle on done or error
    if (fin) begin
      phase_next    = jsu_pkg::PH_IDLE;
      count_next    = 2'd0;
      bad_next      = 1'b0;
      bundle.status = fin_status;
    end
  end

endmodule

FILE: hw/rtl/jsu_out.sv
module jsu_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  jsu_pkg::bundle_t bundle,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic [3:0]       status,
  output logic             last
);

  logic             bun_valid;
  jsu_pkg::bundle_t bun;
  logic [1:0]       idx;
  logic             take;

  assign out_valid  = bun_valid;
  assign out_byte   = bun.bytes[idx];
  assign byte_valid = bun.byte_valid;
  assign status     = bun.status;
  assign last       = (idx == bun.last_idx);
  assign take       = bun_valid & ~out_stall;
  assign free       = ~bun_valid | (take & last);

  // Hold one item's results; step through them one per cycle while out_stall is low
  always_ff @(posedge clk) begin
    if (rst) begin
      bun_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      bun_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (take) begin
      if (last) begin
        bun_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bun <= bundle;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    bun_valid |-> idx <= bun.last_idx)
    else $error("result index past last byte");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != jsu_pkg::ST_BUSY |-> last)
    else $error("final status on a non-last result");

  a_nobyte_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last)
    else $error("status-only item has several results");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result register overwritten");

  a_step: assert property (@(posedge clk) disable iff (rst)
    take && !last && !load |=> bun_valid && idx == $past(idx) + 2'd1)
    else $error("result index did not advance");

endmodule
